[rtl/irsc_pkg.sv]
// irsc_pkg: shared types and constants for the IR sensor scan / peak calibrate block.
// No dependencies; imported by irsc_ctrl, irsc_datapath and the top level.
package irsc_pkg;

   localparam int NUM_SENSORS_DEF = 6;
   localparam int SAMPLE_BITS     = 12;
   localparam int LEVEL_BITS      = 10;
   localparam int CHANNEL_BITS    = 3;
   localparam int PROD_W          = SAMPLE_BITS + LEVEL_BITS;
   localparam int DIV_CNT_W       = $clog2(LEVEL_BITS);

   localparam int REQ_TDATA_W = 24;  // raw_sample, baseline_value
   localparam int REQ_TUSER_W = 2;   // operation
   localparam int RSP_TDATA_W = 32;  // channel, raw_value, level, zero pad

   localparam logic [LEVEL_BITS-1:0]  FULL_SCALE = LEVEL_BITS'(1000);
   localparam logic [SAMPLE_BITS-1:0] MIN_RESET  = SAMPLE_BITS'(100);
   localparam logic [SAMPLE_BITS-1:0] MAX_RESET  = SAMPLE_BITS'(2500);

   typedef enum logic [1:0] {
      OP_SAMPLE       = 2'd0,
      OP_CLEAR_PEAKS  = 2'd1,
      OP_SET_BASELINE = 2'd2,
      OP_APPLY        = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_item;     // input item accepted this cycle
      logic sample_commit; // store sample, update peak, load echo result
      logic apply_setup;   // read channel, multiply, seed divider
      logic div_step;      // one restoring-division step
      logic apply_emit;    // load calibrated result
      logic idx_clear;
      logic idx_next;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type item_op;
      logic   rsp_free;
      logic   div_done;
      logic   idx_last;
   } stat_type;

endpackage

[rtl/irsc_ctrl.sv]
// irsc_ctrl: sequencing state machine for the IR sensor scan block.
// Depends on irsc_pkg (state, command and status types).
module irsc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  irsc_pkg::stat_type stat,
   output irsc_pkg::cmd_type  cmd
);
   import irsc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (stat.item_op)
                  OP_SAMPLE: state_in = ST_SAMPLE;
                  OP_APPLY:  state_in = ST_SETUP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SAMPLE: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         ST_SETUP:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (stat.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.rsp_free) state_in = stat.idx_last ? ST_IDLE : ST_SETUP;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.take_item = req_tvalid;
            cmd.idx_clear = req_tvalid;
         end
         ST_SAMPLE: cmd.sample_commit = stat.rsp_free;
         ST_SETUP:  cmd.apply_setup   = 1'b1;
         ST_DIVIDE: cmd.div_step      = 1'b1;
         ST_EMIT: begin
            cmd.apply_emit = stat.rsp_free;
            cmd.idx_next   = stat.rsp_free & ~stat.idx_last;
         end
         default: cmd = '0;
      endcase
   end

   // results only go into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply_emit || cmd.sample_commit) |-> stat.rsp_free)
      else $error("result loaded while output register busy");

   // the divider always runs its steps between setup and emit
   a_setup_then_div: assert property (@(posedge clock) disable iff (reset)
      cmd.apply_setup |=> cmd.div_step)
      else $error("divide did not follow setup");

   // a new item is never taken while an apply is in flight
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.apply_setup) |-> !req_tready)
      else $error("input ready during apply");

endmodule

[rtl/irsc_datapath.sv]
// irsc_datapath: per-channel stores, peak/baseline update, multiply and
// restoring divider, output register. Depends on irsc_pkg.
module irsc_datapath #(
   parameter int NUM_SENSORS = irsc_pkg::NUM_SENSORS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [irsc_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic [irsc_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  logic                                  csr_valid,
   input  logic                                  csr_data,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [irsc_pkg::CHANNEL_BITS-1:0]     rsp_channel,
   output logic [irsc_pkg::SAMPLE_BITS-1:0]      rsp_raw_value,
   output logic [irsc_pkg::LEVEL_BITS-1:0]       rsp_level,
   output logic                                  rsp_is_calibrated,
   output logic                                  rsp_tlast,
   input  irsc_pkg::cmd_type                     cmd,
   output irsc_pkg::stat_type                    stat
);
   import irsc_pkg::*;

   localparam int CH_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_SENSORS - 1);

   op_type                 item_op;
   logic [SAMPLE_BITS-1:0] in_raw, in_base;

   logic                   peak_en_ff, peak_en_in;
   logic [CH_W-1:0]        scan_ff, scan_in;
   logic [CH_W-1:0]        idx_ff, idx_in;
   logic [SAMPLE_BITS-1:0] raw_store_ff [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] raw_store_in [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] min_ff [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] min_in [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] max_ff [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] max_in [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] item_raw_ff, item_raw_in;

   // apply working registers
   logic [SAMPLE_BITS-1:0] v_ff, v_in;
   logic                   below_ff, below_in;
   logic                   above_ff, above_in;
   logic [SAMPLE_BITS-1:0] den_ff, den_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [LEVEL_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_BITS-1:0] rsp_ch_ff, rsp_ch_in;
   logic [SAMPLE_BITS-1:0]  rsp_raw_ff, rsp_raw_in;
   logic [LEVEL_BITS-1:0]   rsp_lvl_ff, rsp_lvl_in;
   logic                    rsp_cal_ff, rsp_cal_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [SAMPLE_BITS-1:0]  sel_raw, sel_lo, sel_hi, diff;
   logic [PROD_W-1:0]       prod;
   logic [SAMPLE_BITS:0]    trial;
   logic [SAMPLE_BITS:0]    trial_sub;
   logic                    qbit;
   logic                    rsp_free;
   logic [CH_W+CHANNEL_BITS-1:0] scan_ext, idx_ext;

   assign item_op  = op_type'(req_tuser);
   assign in_raw   = req_tdata[SAMPLE_BITS-1:0];
   assign in_base  = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   assign sel_raw = raw_store_ff[idx_ff];
   assign sel_lo  = min_ff[idx_ff];
   assign sel_hi  = max_ff[idx_ff];
   assign diff    = sel_raw - sel_lo;
   assign prod    = PROD_W'(diff) * PROD_W'(FULL_SCALE);

   assign trial     = {rem_ff, quo_ff[LEVEL_BITS-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign qbit      = (trial >= {1'b0, den_ff});

   assign scan_ext = (CH_W + CHANNEL_BITS)'(scan_ff);
   assign idx_ext  = (CH_W + CHANNEL_BITS)'(idx_ff);

   always_comb begin
      peak_en_in   = csr_valid ? csr_data : peak_en_ff;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      raw_store_in = raw_store_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      item_raw_in  = item_raw_ff;
      v_in         = v_ff;
      below_in     = below_ff;
      above_in     = above_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_cal_in   = rsp_cal_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.take_item) begin
         item_raw_in = in_raw;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            if (item_op == OP_CLEAR_PEAKS)  max_in[i] = '0;
            if (item_op == OP_SET_BASELINE) min_in[i] = in_base;
         end
      end

      if (cmd.sample_commit) begin
         raw_store_in[scan_ff] = item_raw_ff;
         if (peak_en_ff && (item_raw_ff > max_ff[scan_ff])) max_in[scan_ff] = item_raw_ff;
         scan_in      = (scan_ff == LAST_CH) ? '0 : scan_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_ch_in    = scan_ext[CHANNEL_BITS-1:0];
         rsp_raw_in   = item_raw_ff;
         rsp_lvl_in   = '0;
         rsp_cal_in   = 1'b0;
         rsp_last_in  = 1'b1;
      end

      if (cmd.idx_clear) idx_in = '0;
      if (cmd.idx_next)  idx_in = idx_ff + 1'b1;

      if (cmd.apply_setup) begin
         v_in     = sel_raw;
         below_in = (sel_raw <= sel_lo);
         above_in = (sel_raw >= sel_hi);
         den_in   = sel_hi - sel_lo;
         // quotient < 2^LEVEL_BITS, so the upper slice is already below den
         rem_in   = prod[PROD_W-1:LEVEL_BITS];
         quo_in   = prod[LEVEL_BITS-1:0];
         cnt_in   = '0;
      end

      if (cmd.div_step) begin
         rem_in = qbit ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         quo_in = {quo_ff[LEVEL_BITS-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.apply_emit) begin
         rsp_valid_in = 1'b1;
         rsp_ch_in    = idx_ext[CHANNEL_BITS-1:0];
         rsp_raw_in   = v_ff;
         rsp_lvl_in   = below_ff ? '0 : (above_ff ? FULL_SCALE : quo_ff);
         rsp_cal_in   = 1'b1;
         rsp_last_in  = (idx_ff == LAST_CH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_en_ff   <= 1'b0;
         scan_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            raw_store_ff[i] <= '0;
            min_ff[i]       <= MIN_RESET;
            max_ff[i]       <= MAX_RESET;
         end
      end else begin
         peak_en_ff   <= peak_en_in;
         scan_ff      <= scan_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         raw_store_ff <= raw_store_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      item_raw_ff <= item_raw_in;
      v_ff        <= v_in;
      below_ff    <= below_in;
      above_ff    <= above_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_cal_ff  <= rsp_cal_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_channel       = rsp_ch_ff;
   assign rsp_raw_value     = rsp_raw_ff;
   assign rsp_level         = rsp_lvl_ff;
   assign rsp_is_calibrated = rsp_cal_ff;
   assign rsp_tlast         = rsp_last_ff;

   assign stat.item_op  = item_op;
   assign stat.rsp_free = rsp_free;
   assign stat.div_done = (cnt_ff == DIV_CNT_W'(LEVEL_BITS - 1));
   assign stat.idx_last = (idx_ff == LAST_CH);

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lvl_ff <= FULL_SCALE))
      else $error("level above full scale");

   a_echo_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_cal_ff) |-> (rsp_last_ff && (rsp_lvl_ff == '0)))
      else $error("sample echo with level or without last");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (scan_ff <= LAST_CH) && (idx_ff <= LAST_CH))
      else $error("channel pointer out of range");

endmodule

[rtl/ir_sensor_scan_peak_calibrate.sv]
// ir_sensor_scan_peak_calibrate: top level of the six-channel IR scan block.
// Depends on irsc_pkg, irsc_ctrl and irsc_datapath.
//
// Usage:
//  - req_* channel: one item per handshake. tuser carries the operation
//    (sample, clear peaks, set baselines, apply); tdata carries raw_sample
//    and baseline_value.
//  - rsp_* channel: result items. A sample gives one echo item (channel, raw,
//    level 0, tuser 0, tlast 1). Apply gives one calibrated item per channel,
//    channel 0 first, tuser 1, tlast on the final channel. Clear peaks and
//    set baselines give no result.
//  - csr_* port: single-bit peak record enable, always ready; the user writes it
//    only while the block is idle, which the block itself does not enforce.
// Sequencing:
//  - clear peaks, set baselines: done on acceptance, ready again next cycle.
//  - sample: accept, then store + load output register once it is free.
//  - apply: after the accept, for each of the six channels: read + multiply,
//    10 restoring-divide steps, load output.
// One item is in flight at a time; the output register holds a result while
// the receiver stalls, and the sequencer waits there before loading the next.
// Reset: scan channel 0, raw store 0, minima 100, maxima 2500, peak record off.
module ir_sensor_scan_peak_calibrate #(
   parameter int NUM_SENSORS = irsc_pkg::NUM_SENSORS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [11:0] raw_sample, [23:12] baseline_value
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [irsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: [1:0] operation
   input  logic [irsc_pkg::REQ_TUSER_W-1:0] req_tuser,
   // rsp_tdata: [2:0] channel, [14:3] raw_value, [24:15] level, [31:25] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [irsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: [0] is_calibrated
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // peak_record_enable
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_data
);
   import irsc_pkg::*;

   localparam int PAD_W = RSP_TDATA_W - CHANNEL_BITS - SAMPLE_BITS - LEVEL_BITS;

   cmd_type                 cmd;
   stat_type                stat;
   logic [CHANNEL_BITS-1:0] rsp_channel;
   logic [SAMPLE_BITS-1:0]  rsp_raw_value;
   logic [LEVEL_BITS-1:0]   rsp_level;

   irsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   irsc_datapath #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_channel       (rsp_channel),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_level         (rsp_level),
      .rsp_is_calibrated (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .cmd               (cmd),
      .stat              (stat)
   );

   // register write is a single flop, never stalls
   assign csr_ready = 1'b1;

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_level, rsp_raw_value, rsp_channel};

endmodule

[bench/tb.sv]
// tb: self-checking bench for ir_sensor_scan_peak_calibrate (scan, peak track, calibrate).
// Depends on irsc_pkg and the RTL top level; holds the calibration scoreboard class
// and the stream drivers.

typedef struct packed {
   logic [2:0]  channel;
   logic [11:0] raw_value;
   logic [9:0]  level;
   logic        is_calibrated;
   logic        is_last;
} calib_result_type;

// Tracks the scanner state and the queue of results it should produce.
class calib_scoreboard;
   localparam int NS = irsc_pkg::NUM_SENSORS_DEF;

   bit               peak_record;
   int unsigned      scan_ch;
   logic [11:0]      raw_mem [NS];
   logic [11:0]      lo_mem [NS];
   logic [11:0]      hi_mem [NS];
   calib_result_type pending_q[$];
   int               errors;
   int               results_seen;
   int               op_count [4];

   function new();
      peak_record = 1'b0;
      scan_ch = 0;
      errors = 0;
      results_seen = 0;
      foreach (op_count[i]) op_count[i] = 0;
      for (int i = 0; i < NS; i++) begin
         raw_mem[i] = '0;
         lo_mem[i]  = irsc_pkg::MIN_RESET;
         hi_mem[i]  = irsc_pkg::MAX_RESET;
      end
   endfunction

   function void write_peak(bit v);
      peak_record = v;
   endfunction

   function int pending();
      return pending_q.size();
   endfunction

   // 0 at or below the minimum, full scale at or above the maximum (checked second)
   function logic [9:0] scaled_level(logic [11:0] v, logic [11:0] lo, logic [11:0] hi);
      int unsigned num;
      int unsigned span;
      if (v <= lo) return '0;
      if (v >= hi) return irsc_pkg::FULL_SCALE;
      num  = (int'(v) - int'(lo)) * 1000;
      span = int'(hi) - int'(lo);
      return 10'(num / span);
   endfunction

   function void note_item(irsc_pkg::op_type op, logic [11:0] raw, logic [11:0] base);
      calib_result_type r;
      op_count[op]++;
      case (op)
         irsc_pkg::OP_SAMPLE: begin
            raw_mem[scan_ch] = raw;
            if (peak_record && raw > hi_mem[scan_ch]) hi_mem[scan_ch] = raw;
            r = '{channel: 3'(scan_ch), raw_value: raw, level: '0,
                  is_calibrated: 1'b0, is_last: 1'b1};
            pending_q.push_back(r);
            scan_ch = (scan_ch + 1 >= NS) ? 0 : scan_ch + 1;
         end
         irsc_pkg::OP_CLEAR_PEAKS: begin
            for (int i = 0; i < NS; i++) hi_mem[i] = '0;
         end
         irsc_pkg::OP_SET_BASELINE: begin
            for (int i = 0; i < NS; i++) lo_mem[i] = base;
         end
         default: begin
            for (int i = 0; i < NS; i++) begin
               r = '{channel: 3'(i), raw_value: raw_mem[i],
                     level: scaled_level(raw_mem[i], lo_mem[i], hi_mem[i]),
                     is_calibrated: 1'b1, is_last: (i == NS - 1)};
               pending_q.push_back(r);
            end
         end
      endcase
   endfunction

   task report_mismatch(string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      errors++;
   endtask

   task check_result(logic [irsc_pkg::RSP_TDATA_W-1:0] data, logic user, logic lastflag);
      calib_result_type want;
      results_seen++;
      if (pending_q.size() == 0) begin
         report_mismatch($sformatf("unexpected item, tdata %h", data));
      end else begin
         want = pending_q.pop_front();
         if (data[2:0] != want.channel)
            report_mismatch($sformatf("channel %0d, expected %0d", data[2:0], want.channel));
         if (data[14:3] != want.raw_value)
            report_mismatch($sformatf("raw %0d, expected %0d", data[14:3], want.raw_value));
         if (data[24:15] != want.level)
            report_mismatch($sformatf("level %0d, expected %0d (ch %0d)",
                                      data[24:15], want.level, want.channel));
         if (data[31:25] != '0)
            report_mismatch($sformatf("pad bits %h not zero", data[31:25]));
         if (user != want.is_calibrated)
            report_mismatch($sformatf("tuser %0b, expected %0b", user, want.is_calibrated));
         if (lastflag != want.is_last)
            report_mismatch($sformatf("tlast %0b, expected %0b", lastflag, want.is_last));
      end
   endtask
endclass

module tb;
   import irsc_pkg::*;

   // Long enough for an apply to finish; waited out before touching the CSR or ending.
   localparam int DRAIN_CYCLES = 90;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 109;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [11:0] raw_sample, [23:12] baseline_value
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;   // [1:0] operation
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [2:0] channel, [14:3] raw, [24:15] level
   logic                   rsp_tuser;         // [0] is_calibrated
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic                   csr_data   = 1'b0;

   // Flags owned by the stimulus process, read by the ready generator.
   bit          calm        = 1'b0;
   int          hold_ticket = 0;
   int          hold_served = 0;
   int          hold_left   = 0;
   int unsigned cycle_count = 0;
   int          csr_writes  = 0;

   calib_scoreboard sb;

   ir_sensor_scan_peak_calibrate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side ready. A new hold ticket holds ready low until a count from HOLD_CYCLES
   // runs out, so the block backs up into its input; calm phases keep ready high throughout.
   always @(posedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 28);
      end
   end

   // Values sampled here are the pre-edge ones, so no ordering race with the DUT.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Offer one item and hold it until accepted. Valid stays high into the next
   // item unless a random gap is taken, so it is never dropped and raised in one step.
   task send_item(input op_type op, input logic [11:0] raw, input logic [11:0] base);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {base, raw};
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, raw, base);
      if (!calm && $urandom_range(99) < 28) begin
         // mostly short gaps, now and then one long enough to land mid-apply
         gap = ($urandom_range(9) == 0) ? $urandom_range(5, 90) : $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, let every expected item drain, then allow for a trailing
   // clear/baseline op that produces nothing.
   task settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_peak_enable(input bit v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_peak(v);
      csr_writes++;
   endtask

   // Readings bunch at the rails and around the reset min/max so clamps and
   // the linear region all get exercised.
   function logic [11:0] pick_reading();
      case ($urandom_range(7))
         0:       return 12'd0;
         1:       return 12'hFFF;
         2:       return 12'($urandom_range(0, 300));
         3:       return 12'($urandom_range(2000, 3000));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   function logic [11:0] pick_baseline();
      case ($urandom_range(7))
         0:       return 12'd0;
         1:       return 12'hFFF;
         2, 3:    return 12'($urandom_range(0, 4095));
         default: return 12'($urandom_range(50, 600));
      endcase
   endfunction

   // Clearing peaks with recording off pins every max at zero, so do it rarely then.
   task random_item();
      int          pick;
      op_type      op;
      logic [11:0] raw;
      logic [11:0] base;
      pick = $urandom_range(99);
      raw  = pick_reading();
      base = pick_baseline();
      if (pick < 62)                       op = OP_SAMPLE;
      else if (pick < 80)                  op = OP_APPLY;
      else if (pick < 92)                  op = OP_SET_BASELINE;
      else if (pick < 94 || sb.peak_record) op = OP_CLEAR_PEAKS;
      else                                 op = OP_SAMPLE;
      send_item(op, raw, base);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fresh from reset: all raw 0, min 100, so every level clamps to 0.
      send_item(OP_APPLY, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
      // Seven samples: rails, exactly at min and max, midpoint, just below min,
      // and a seventh that wraps back to channel 0.
      send_item(OP_SAMPLE, 12'd0,    12'hFFF);
      send_item(OP_SAMPLE, 12'hFFF,  12'd0);
      send_item(OP_SAMPLE, 12'd100,  12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd2500, 12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd1300, 12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd99,   12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd2499, 12'($urandom_range(4095)));
      send_item(OP_APPLY,  12'hFFF,  12'hFFF);
      // Baseline at the top rail: everything at or below min.
      send_item(OP_SET_BASELINE, 12'hFFF, 12'hFFF);
      send_item(OP_APPLY,  12'($urandom_range(4095)), 12'($urandom_range(4095)));
      send_item(OP_SET_BASELINE, 12'($urandom_range(4095)), 12'd0);
      send_item(OP_APPLY,  12'd0, 12'd0);
      // Max cleared to 0, at or below min: nonzero raw reads full scale.
      send_item(OP_CLEAR_PEAKS, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
      send_item(OP_APPLY,  12'd0, 12'd0);
      send_item(OP_SET_BASELINE, 12'd0, 12'd100);

      // Peak recording on: samples now pull the cleared maxima up.
      write_peak_enable(1'b1);
      send_item(OP_SAMPLE, 12'd50,   12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'hFFF,  12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd0,    12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd2000, 12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd101,  12'($urandom_range(4095)));
      send_item(OP_SAMPLE, 12'd3000, 12'($urandom_range(4095)));
      send_item(OP_APPLY,  12'($urandom_range(4095)), 12'($urandom_range(4095)));

      // Random phases alternate the peak enable. Phase 1 starts with a long
      // receiver hold-off while items keep coming; phase 2 has no idling at all.
      for (int phase = 0; phase < 4; phase++) begin
         write_peak_enable(phase % 2 == 0);
         calm <= (phase == 2);
         if (phase == 1) hold_ticket <= hold_ticket + 1;
         repeat (PHASE_ITEMS) random_item();
      end
      settle();

      $display("covered %0d samples, %0d applies, %0d peak clears, %0d baseline sets",
               sb.op_count[OP_SAMPLE], sb.op_count[OP_APPLY], sb.op_count[OP_CLEAR_PEAKS],
               sb.op_count[OP_SET_BASELINE]);
      $display("%0d csr writes, checked %0d result items, %0d mismatches, %0d left over",
               csr_writes, sb.results_seen, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
